/* rtl/core/random_cyclic_permutation_table_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the random cyclic permutation table checker.
// Every macro samples on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANDOM_CYCLIC_PERMUTATION_TABLE_MACROS_SVH
`define RANDOM_CYCLIC_PERMUTATION_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpt checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define RCPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpt checker: next-cycle property failed");

// Read latency check: the consequent must follow the antecedent.
`define RCPT_ASSERT_LAT3(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("rcpt checker: read latency property failed");

`endif

/* rtl/core/rcpt_pkg.sv */
// ----------------------------------------------------------------------------
// rcpt_pkg
// Shared types and constants of the random cyclic permutation table.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpt_pkg;

    // Default sizing of the table.
    localparam int TABLE_ENTRIES_DEFAULT = 256;
    localparam int INDEX_BITS_DEFAULT    = 8;

    // Field widths fixed by the interface.
    localparam int SEED_W  = 32;
    localparam int INDEX_W = 8;
    localparam int ENTRY_W = 8;
    localparam int GEN_W   = 32;

    // Multiply-with-carry generator constants.
    localparam logic [GEN_W-1:0] MWC_FACTOR = 32'd1791398085;
    localparam logic [GEN_W-1:0] MWC_START  = 32'd30903;
    localparam logic [GEN_W-1:0] HALF_MASK  = 32'd65535;
    localparam int               HALF_SHIFT = 16;
    localparam logic [HALF_SHIFT-1:0] MWC_FACTOR_HI = 16'(MWC_FACTOR >> HALF_SHIFT);
    localparam logic [HALF_SHIFT-1:0] MWC_FACTOR_LO = 16'(MWC_FACTOR & HALF_MASK);

    // Operation and result kind codes.
    localparam logic OP_BUILD   = 1'b0;
    localparam logic OP_READ    = 1'b1;
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic               opcode;
        logic [SEED_W-1:0]  seed;
        logic [INDEX_W-1:0] index;
    } rcpt_item_t;

    // One result transaction.
    typedef struct packed {
        logic               kind;
        logic [ENTRY_W-1:0] entry;
    } rcpt_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // latch the read index
        logic load_gen;    // reseed the generator from the item
        logic cnt_clear;
        logic cnt_inc;
        logic init_wr;     // write the starting cycle into both tables
        logic gen_mul;     // form the four half-word products
        logic gen_add;     // new value and provisional carry
        logic sw_a;        // carry fixup, draw j, read F[i] and B[j]
        logic sw_b;        // read F[j] and B[fi]
        logic sw_c;        // read F[bj] and B[fj]
        logic sw_d;        // write F[i] and B[fi]
        logic sw_e;        // write F[bj] and B[fj]
        logic sw_f;        // write F[j] and B[j]
        logic rd_addr;     // read F[index]
        logic emit_read;
        logic emit_build;
    } rcpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
    } rcpt_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rcpt_ctrl.sv */
// ----------------------------------------------------------------------------
// rcpt_ctrl
// Sequencer for table builds and reads; issues one command set per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               opcode,
    input  rcpt_pkg::rcpt_stat_t    stat,
    output rcpt_pkg::rcpt_cmd_t     cmd,
    output logic                    busy
);

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_INIT    = 12'b0000_0000_0010,
        ST_GEN_MUL = 12'b0000_0000_0100,
        ST_GEN_ADD = 12'b0000_0000_1000,
        ST_SW_A    = 12'b0000_0001_0000,
        ST_SW_B    = 12'b0000_0010_0000,
        ST_SW_C    = 12'b0000_0100_0000,
        ST_SW_D    = 12'b0000_1000_0000,
        ST_SW_E    = 12'b0001_0000_0000,
        ST_SW_F    = 12'b0010_0000_0000,
        ST_RD_ADDR = 12'b0100_0000_0000,
        ST_RD_DATA = 12'b1000_0000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    if (opcode == rcpt_pkg::OP_READ)
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else
                    begin
                        cmd.load_gen = 1'b1;
                        state_next   = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_GEN_MUL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_GEN_MUL:
            begin
                cmd.gen_mul = 1'b1;
                state_next  = ST_GEN_ADD;
            end
            ST_GEN_ADD:
            begin
                cmd.gen_add = 1'b1;
                state_next  = ST_SW_A;
            end
            ST_SW_A:
            begin
                cmd.sw_a   = 1'b1;
                state_next = ST_SW_B;
            end
            ST_SW_B:
            begin
                cmd.sw_b   = 1'b1;
                state_next = ST_SW_C;
            end
            ST_SW_C:
            begin
                cmd.sw_c   = 1'b1;
                state_next = ST_SW_D;
            end
            ST_SW_D:
            begin
                cmd.sw_d   = 1'b1;
                state_next = ST_SW_E;
            end
            ST_SW_E:
            begin
                // The next draw starts while the last writes go out.
                cmd.sw_e    = 1'b1;
                cmd.gen_mul = !stat.cnt_last;
                state_next  = ST_SW_F;
            end
            ST_SW_F:
            begin
                cmd.sw_f    = 1'b1;
                cmd.gen_add = !stat.cnt_last;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.emit_build = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SW_A;
                end
            end
            ST_RD_ADDR:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/core/rcpt_datapath.sv */
// ----------------------------------------------------------------------------
// rcpt_datapath
// Generator, entry counter, forward and backward table memories and the
// result register, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpt_datapath #(
    parameter int TABLE_ENTRIES = rcpt_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int INDEX_BITS    = rcpt_pkg::INDEX_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  rcpt_pkg::rcpt_item_t      item,
    input  rcpt_pkg::rcpt_cmd_t       cmd,
    output rcpt_pkg::rcpt_stat_t      stat,
    output logic                      done,
    output rcpt_pkg::rcpt_result_t    result
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] MASK = AW'(TABLE_ENTRIES - 1);
    localparam int GW = rcpt_pkg::GEN_W;
    localparam int HS = rcpt_pkg::HALF_SHIFT;

    // Table memories.
    logic [AW-1:0] fwd_mem [TABLE_ENTRIES];
    logic [AW-1:0] bwd_mem [TABLE_ENTRIES];

    logic [AW-1:0] f_raddr, b_raddr, f_waddr, b_waddr, f_wdata, b_wdata;
    logic          f_we, b_we;
    logic [AW-1:0] f_rdata_reg, b_rdata_reg;

    // Generator and sequencing registers.
    logic [GW-1:0] val_reg, val_next, carry_reg, carry_next;
    logic [GW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, csum_reg;
    logic [GW-1:0] pa_next, pb_next, pc_next, pd_next, csum_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] j_reg, tf_reg, fi_reg, bj_reg, fj_reg, tb_reg, v1_reg, w1_reg;
    logic [AW-1:0] index_reg;
    logic          done_reg, done_next;
    rcpt_pkg::rcpt_result_t result_reg, result_next;

    logic [HS-1:0] xh, xl;
    logic [AW-1:0] j_draw, bj_addr, fj_addr, cnt_plus, cnt_minus;

    assign xh        = val_reg[GW-1:HS];
    assign xl        = val_reg[HS-1:0];
    assign j_draw    = AW'(val_reg >> (GW - INDEX_BITS)) & MASK;
    assign bj_addr   = bj_reg & MASK;
    assign fj_addr   = fj_reg & MASK;
    assign cnt_plus  = AW'({1'b0, cnt_reg} + (AW+1)'(1)) & MASK;
    assign cnt_minus = AW'({1'b0, cnt_reg} + {1'b0, MASK}) & MASK;

    assign stat.cnt_last = (cnt_reg == MASK);

    // Generator: four half-word products, then the sums, then the carry fixup.
    always_comb
    begin
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        pd_next    = pd_reg;
        csum_next  = csum_reg;
        val_next   = val_reg;
        carry_next = carry_reg;
        if (cmd.load_gen)
        begin
            val_next   = rcpt_pkg::MWC_START;
            carry_next = item.seed;
        end
        if (cmd.gen_mul)
        begin
            pa_next = {16'b0, xh} * {16'b0, rcpt_pkg::MWC_FACTOR_HI};
            pb_next = {16'b0, xh} * {16'b0, rcpt_pkg::MWC_FACTOR_LO};
            pc_next = {16'b0, xl} * {16'b0, rcpt_pkg::MWC_FACTOR_HI};
            pd_next = {16'b0, xl} * {16'b0, rcpt_pkg::MWC_FACTOR_LO};
        end
        if (cmd.gen_add)
        begin
            val_next  = pd_reg + ((pb_reg + pc_reg) << HS) + carry_reg;
            csum_next = pa_reg + (pb_reg >> HS) + (pc_reg >> HS);
        end
        if (cmd.sw_a)
        begin
            carry_next = csum_reg + {31'b0, (pd_reg >= (32'd0 - csum_reg))};
        end
    end

    // Entry counter, shared by the fill and the swap passes.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = AW'({1'b0, cnt_reg} + (AW+1)'(1));
        end
    end

    // Memory address and data selection.
    always_comb
    begin
        f_raddr = cnt_reg;
        b_raddr = j_draw;
        f_we    = 1'b0;
        b_we    = 1'b0;
        f_waddr = cnt_reg;
        b_waddr = cnt_reg;
        f_wdata = cnt_plus;
        b_wdata = cnt_minus;
        priority if (cmd.init_wr)
        begin
            f_we = 1'b1;
            b_we = 1'b1;
        end
        else if (cmd.sw_b)
        begin
            f_raddr = j_reg;
            b_raddr = f_rdata_reg & MASK;
        end
        else if (cmd.sw_c)
        begin
            f_raddr = bj_addr;
            b_raddr = f_rdata_reg & MASK;
        end
        else if (cmd.sw_d)
        begin
            f_we    = 1'b1;
            b_we    = 1'b1;
            f_waddr = cnt_reg;
            f_wdata = f_rdata_reg;
            b_waddr = fi_reg;
            b_wdata = b_rdata_reg;
        end
        else if (cmd.sw_e)
        begin
            // F[j] and B[j] as they stand after the first writes.
            f_we    = 1'b1;
            b_we    = 1'b1;
            f_waddr = bj_addr;
            f_wdata = (j_reg == cnt_reg) ? v1_reg : fj_reg;
            b_waddr = fj_addr;
            b_wdata = (j_reg == fi_reg) ? w1_reg : bj_reg;
        end
        else if (cmd.sw_f)
        begin
            f_we    = 1'b1;
            b_we    = 1'b1;
            f_waddr = j_reg;
            f_wdata = tf_reg;
            b_waddr = j_reg;
            b_wdata = tb_reg;
        end
        else if (cmd.rd_addr)
        begin
            f_raddr = index_reg & MASK;
        end
        else
        begin
            f_raddr = cnt_reg;
        end
    end

    // Forward and backward memories with registered read data.
    always_ff @(posedge clk)
    begin
        f_rdata_reg <= fwd_mem[f_raddr];
        b_rdata_reg <= bwd_mem[b_raddr];
        if (f_we)
        begin
            fwd_mem[f_waddr] <= f_wdata;
        end
        if (b_we)
        begin
            bwd_mem[b_waddr] <= b_wdata;
        end
    end

    // Result register.
    always_comb
    begin
        done_next   = cmd.emit_read || cmd.emit_build;
        result_next = result_reg;
        if (cmd.emit_read)
        begin
            result_next.kind  = rcpt_pkg::KIND_READ;
            result_next.entry = rcpt_pkg::ENTRY_W'(f_rdata_reg);
        end
        else if (cmd.emit_build)
        begin
            result_next.kind  = rcpt_pkg::KIND_BUILD;
            result_next.entry = '0;
        end
    end

    // Control state and generator state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg   <= '0;
            carry_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            val_reg   <= val_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers captured along the swap sequence.
    always_ff @(posedge clk)
    begin
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pc_reg     <= pc_next;
        pd_reg     <= pd_next;
        csum_reg   <= csum_next;
        result_reg <= result_next;
        if (cmd.load_item)
        begin
            index_reg <= AW'(item.index);
        end
        if (cmd.sw_a)
        begin
            j_reg <= j_draw;
        end
        if (cmd.sw_b)
        begin
            tf_reg <= f_rdata_reg;
            fi_reg <= f_rdata_reg & MASK;
            bj_reg <= b_rdata_reg;
        end
        if (cmd.sw_c)
        begin
            fj_reg <= f_rdata_reg;
            tb_reg <= b_rdata_reg;
        end
        if (cmd.sw_d)
        begin
            v1_reg <= f_rdata_reg;
            w1_reg <= b_rdata_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/random_cyclic_permutation_table.sv */
// ----------------------------------------------------------------------------
// random_cyclic_permutation_table
// Builds a random single-cycle permutation of TABLE_ENTRIES positions from a
// seeded multiply-with-carry generator and answers successor lookups.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A build first
// fills both tables, forms the first draw, then does the swaps in three
// read steps and three write steps per entry, since each table has one read
// port and one write port and every entry needs three reads and three writes
// on each; done rises once the writes of the last entry are out. A read
// addresses the forward table in ST_RD_ADDR and moves the registered memory
// data into result in ST_RD_DATA. Each result is on result for one cycle
// with done high and must be taken then: there is no way to hold it off.
// busy is low while done is shown, so the next transaction may be started
// in that cycle. Reading before the first build returns undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module random_cyclic_permutation_table #(
    parameter int TABLE_ENTRIES = rcpt_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int INDEX_BITS    = rcpt_pkg::INDEX_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  rcpt_pkg::rcpt_item_t      item,
    output logic                      done,
    output rcpt_pkg::rcpt_result_t    result
);

    rcpt_pkg::rcpt_cmd_t  cmd;
    rcpt_pkg::rcpt_stat_t stat;

    // Sequencer.
    rcpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Generator, tables and result register.
    rcpt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .INDEX_BITS    (INDEX_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

/* rtl/core/rcpt_checker.sv */
// ----------------------------------------------------------------------------
// rcpt_checker
// Port-level timing checks for the random cyclic permutation table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "random_cyclic_permutation_table_macros.svh"

module rcpt_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input rcpt_pkg::rcpt_item_t        item,
    input wire logic                   done,
    input rcpt_pkg::rcpt_result_t      result
);

    // An accepted transaction makes the block busy.
    `RCPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A result is shown only once the block is free again.
    `RCPT_ASSERT_SAME(a_done_idle, done, !busy)

    // Results never come in two adjacent cycles.
    `RCPT_ASSERT_NEXT(a_done_single, done, !done)

    // A read answers with a read-kind result and done high.
    `RCPT_ASSERT_LAT3(a_read_latency, start && !busy && (item.opcode == rcpt_pkg::OP_READ),
        done && (result.kind == rcpt_pkg::KIND_READ))

    // A build acknowledgement carries a zero entry.
    `RCPT_ASSERT_SAME(a_build_zero, done && (result.kind == rcpt_pkg::KIND_BUILD),
        result.entry == '0)

endmodule

bind random_cyclic_permutation_table rcpt_checker u_checker (.*);

`default_nettype wire
